// File: design/crrt_pkg.sv
// Shared types, constants and helpers of the retransmit table.
package crrt_pkg;

    // Table geometry.
    localparam int TABLE_SLOTS = 16;
    localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

    // Field widths.
    localparam int REQ_W    = 2;
    localparam int ID_W     = 29;
    localparam int LEN_W    = 4;
    localparam int DATA_W   = 64;
    localparam int RES_W    = 6;
    localparam int STATUS_W = 3;
    localparam int REAPED_W = 7;

    localparam logic [RES_W-1:0] RES_MAX            = 6'd63;
    localparam logic [RES_W-1:0] RESEND_LIMIT_RESET = 6'd15;

    // Request types.
    localparam logic [REQ_W-1:0] REQ_SEND    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CONFIRM = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POLL    = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_ADDED     = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_UPDATED   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_REMOVED   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_DATA_MIS  = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_LEN_MIS   = 3'd5;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd6;
    localparam logic [STATUS_W-1:0] STAT_POLLED    = 3'd7;

    // One table slot as held in the slot memory.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
        logic [RES_W-1:0]  res;
    } t_entry;

    // Write request into the slot memory.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           entry;
    } t_ram_wr;

    // Mask that keeps the first len data bytes; lengths of eight and more keep all.
    function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int k = 0; k < DATA_W / 8; k++) begin
            if (len > LEN_W'(k)) begin
                m[8*k +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

// File: design/crrt_slot_ram.sv
// Slot memory of the retransmit table with one read and one write port.
module crrt_slot_ram
    import crrt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_entry           o_rd_entry,
    output logic             o_rd_written,
    input  t_ram_wr          i_wr
);

    t_entry                 r_mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] r_written;
    t_entry                 r_rd_entry;
    logic                   r_rd_written;

    // Slot storage and registered read data.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.entry;
        end
        if (i_rd_en) begin
            r_rd_entry <= r_mem[i_rd_addr];
        end
    end

    // Written flags: a slot never written reads as free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_written[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_written <= r_written[i_rd_addr];
            end
        end
    end

    assign o_rd_entry   = r_rd_entry;
    assign o_rd_written = r_rd_written;

endmodule

// File: design/can_reliable_retransmit_table_core.sv
// Top level of the CAN retransmit table: request sequencer and result register.
//
//  Channel  Direction  Handshake                  Beat contents
//  in       input      i_in_valid / o_in_stall    req_type, frame_id, frame_length, frame_data
//  out      output     o_out_valid / i_out_stall  tx_valid, tx_id, tx_length, tx_data,
//                                                 status, reaped_count
//  cfg      input      i_cfg_valid / o_cfg_ready  resend_limit
//
// Send, confirm and poll requests each scan all TABLE_SLOTS slots through the one
// read port of the slot memory before their result is loaded; other request types
// go straight to the result. Poll ticks write each occupied slot back during the scan;
// send and confirm write at most once at the end.
// Reset is synchronous and leaves every slot free with no clearing pass.
// A new request is accepted while a result waits; a stalled result holds the next
// request in S_FIN until the result register frees up.
module can_reliable_retransmit_table_core
    import crrt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [ID_W-1:0]     i_frame_id,
    input  logic [LEN_W-1:0]    i_frame_length,
    input  logic [DATA_W-1:0]   i_frame_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_tx_valid,
    output logic [ID_W-1:0]     o_tx_id,
    output logic [LEN_W-1:0]    o_tx_length,
    output logic [DATA_W-1:0]   o_tx_data,
    output logic [STATUS_W-1:0] o_status,
    output logic [REAPED_W-1:0] o_reaped_count,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [RES_W-1:0]    i_cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] r_state, n_state;

    // Captured request.
    logic [REQ_W-1:0]  r_req, n_req;
    logic [ID_W-1:0]   r_id, n_id;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [DATA_W-1:0] r_data, n_data;

    // Scan address and read pipeline.
    logic [CNT_W-1:0] r_rd_idx, n_rd_idx;
    logic             r_pend;
    logic [IDX_W-1:0] r_pidx;

    // Send and confirm bookkeeping.
    logic             r_hit, n_hit;
    logic [IDX_W-1:0] r_hit_idx, n_hit_idx;
    logic             r_len_ok, n_len_ok;
    logic             r_data_ok, n_data_ok;
    logic             r_free, n_free;
    logic [IDX_W-1:0] r_free_idx, n_free_idx;

    // Poll bookkeeping.
    logic                r_found, n_found;
    logic [ID_W-1:0]     r_tx_id, n_tx_id;
    logic [LEN_W-1:0]    r_tx_len, n_tx_len;
    logic [DATA_W-1:0]   r_tx_data, n_tx_data;
    logic [REAPED_W-1:0] r_reaped, n_reaped;

    // Result register.
    logic                r_out_vld, n_out_vld;
    logic                r_o_tx_v, n_o_tx_v;
    logic [ID_W-1:0]     r_o_id, n_o_id;
    logic [LEN_W-1:0]    r_o_len, n_o_len;
    logic [DATA_W-1:0]   r_o_data, n_o_data;
    logic [STATUS_W-1:0] r_o_status, n_o_status;
    logic [REAPED_W-1:0] r_o_reaped, n_o_reaped;

    logic [RES_W-1:0] r_limit;

    // Memory interface and scan helpers.
    logic             issue;
    logic [IDX_W-1:0] rd_addr;
    t_entry           rd_entry;
    logic             rd_written;
    t_ram_wr          wr;
    logic             in_acc;
    logic             occ;
    logic [RES_W-1:0] bumped;
    logic [RES_W-1:0] poll_res;
    logic [LEN_W-1:0] poll_len;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign issue       = (r_state == S_SCAN) && (r_rd_idx < CNT_W'(TABLE_SLOTS));
    assign rd_addr     = r_rd_idx[IDX_W-1:0];

    crrt_slot_ram u_ram (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_en      (issue),
        .i_rd_addr    (rd_addr),
        .o_rd_entry   (rd_entry),
        .o_rd_written (rd_written),
        .i_wr         (wr)
    );

    // Sequencer: capture, scan the slots, then produce the result and the final write.
    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_id       = r_id;
        n_len      = r_len;
        n_data     = r_data;
        n_rd_idx   = r_rd_idx;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_len_ok   = r_len_ok;
        n_data_ok  = r_data_ok;
        n_free     = r_free;
        n_free_idx = r_free_idx;
        n_found    = r_found;
        n_tx_id    = r_tx_id;
        n_tx_len   = r_tx_len;
        n_tx_data  = r_tx_data;
        n_reaped   = r_reaped;
        n_out_vld  = r_out_vld;
        n_o_tx_v   = r_o_tx_v;
        n_o_id     = r_o_id;
        n_o_len    = r_o_len;
        n_o_data   = r_o_data;
        n_o_status = r_o_status;
        n_o_reaped = r_o_reaped;
        wr         = '0;

        occ      = rd_written && (rd_entry.len != '0);
        bumped   = (rd_entry.res == RES_MAX) ? rd_entry.res : rd_entry.res + RES_W'(1);
        poll_res = rd_entry.res;
        poll_len = rd_entry.len;

        // The result beat leaves when the consumer takes it.
        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_req      = i_req_type;
                    n_id       = i_frame_id;
                    n_len      = i_frame_length;
                    n_data     = i_frame_data & byte_mask(i_frame_length);
                    n_rd_idx   = '0;
                    n_hit      = 1'b0;
                    n_len_ok   = 1'b0;
                    n_data_ok  = 1'b0;
                    n_free     = 1'b0;
                    n_found    = 1'b0;
                    n_tx_id    = '0;
                    n_tx_len   = '0;
                    n_tx_data  = '0;
                    n_reaped   = '0;
                    if (i_req_type == REQ_SEND || i_req_type == REQ_CONFIRM ||
                        i_req_type == REQ_POLL) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_SCAN: begin
                if (issue) begin
                    n_rd_idx = r_rd_idx + CNT_W'(1);
                end
                if (r_pend) begin
                    if (r_req == REQ_POLL) begin
                        // Bump slots up to the first one with a nonzero count, then reap.
                        if (occ) begin
                            if (!r_found) begin
                                poll_res = bumped;
                                if (rd_entry.res != '0) begin
                                    n_found   = 1'b1;
                                    n_tx_id   = rd_entry.id;
                                    n_tx_len  = rd_entry.len;
                                    n_tx_data = rd_entry.data;
                                end
                            end
                            if (poll_res >= r_limit) begin
                                poll_len = '0;
                                n_reaped = r_reaped + REAPED_W'(1);
                            end
                            wr.en    = 1'b1;
                            wr.addr  = r_pidx;
                            wr.entry = '{id: rd_entry.id, len: poll_len,
                                         data: rd_entry.data, res: poll_res};
                        end
                    end else begin
                        // Remember the first matching slot and the first free slot.
                        if (occ && rd_entry.id == r_id && !r_hit) begin
                            n_hit     = 1'b1;
                            n_hit_idx = r_pidx;
                            n_len_ok  = (rd_entry.len == r_len);
                            n_data_ok = (rd_entry.data == r_data);
                        end
                        if (!occ && !r_free) begin
                            n_free     = 1'b1;
                            n_free_idx = r_pidx;
                        end
                    end
                end
                if (!issue && !r_pend) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld  = 1'b1;
                    n_o_tx_v   = 1'b0;
                    n_o_id     = '0;
                    n_o_len    = '0;
                    n_o_data   = '0;
                    n_o_reaped = '0;
                    n_o_status = STAT_NOT_FOUND;
                    n_state    = S_IDLE;
                    if (r_req == REQ_SEND) begin
                        n_o_tx_v = 1'b1;
                        n_o_id   = r_id;
                        n_o_len  = r_len;
                        n_o_data = r_data;
                        wr.entry = '{id: r_id, len: r_len, data: r_data, res: '0};
                        if (r_hit) begin
                            wr.en      = 1'b1;
                            wr.addr    = r_hit_idx;
                            n_o_status = STAT_UPDATED;
                        end else if (r_free) begin
                            wr.en      = 1'b1;
                            wr.addr    = r_free_idx;
                            n_o_status = STAT_ADDED;
                        end else begin
                            n_o_status = STAT_FULL;
                        end
                    end else if (r_req == REQ_CONFIRM) begin
                        if (!r_hit) begin
                            n_o_status = STAT_NOT_FOUND;
                        end else if (!r_len_ok) begin
                            n_o_status = STAT_LEN_MIS;
                        end else if (!r_data_ok) begin
                            n_o_status = STAT_DATA_MIS;
                        end else begin
                            // Freeing only needs the length cleared.
                            wr.en      = 1'b1;
                            wr.addr    = r_hit_idx;
                            wr.entry   = '{id: r_id, len: '0, data: r_data, res: '0};
                            n_o_status = STAT_REMOVED;
                        end
                    end else if (r_req == REQ_POLL) begin
                        n_o_tx_v   = r_found;
                        n_o_id     = r_tx_id;
                        n_o_len    = r_tx_len;
                        n_o_data   = r_tx_data;
                        n_o_status = STAT_POLLED;
                        n_o_reaped = r_reaped;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
            r_limit   <= RESEND_LIMIT_RESET;
        end else begin
            r_state   <= n_state;
            r_pend    <= issue;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    // Payload and bookkeeping registers.
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_id       <= n_id;
        r_len      <= n_len;
        r_data     <= n_data;
        r_rd_idx   <= n_rd_idx;
        r_pidx     <= rd_addr;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_len_ok   <= n_len_ok;
        r_data_ok  <= n_data_ok;
        r_free     <= n_free;
        r_free_idx <= n_free_idx;
        r_found    <= n_found;
        r_tx_id    <= n_tx_id;
        r_tx_len   <= n_tx_len;
        r_tx_data  <= n_tx_data;
        r_reaped   <= n_reaped;
        r_o_tx_v   <= n_o_tx_v;
        r_o_id     <= n_o_id;
        r_o_len    <= n_o_len;
        r_o_data   <= n_o_data;
        r_o_status <= n_o_status;
        r_o_reaped <= n_o_reaped;
    end

    assign o_out_valid    = r_out_vld;
    assign o_tx_valid     = r_o_tx_v;
    assign o_tx_id        = r_o_id;
    assign o_tx_length    = r_o_len;
    assign o_tx_data      = r_o_data;
    assign o_status       = r_o_status;
    assign o_reaped_count = r_o_reaped;

`ifndef NO_ASSERTIONS
    // A scan write-back never hits the slot being read in the same cycle.
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr.en && issue) |-> (wr.addr != rd_addr))
        else $error("slot write collides with slot read");

    // Read data only arrives while scanning.
    a_pend_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_SCAN))
        else $error("slot read data outside of a scan");

    // A waiting result is never overwritten by the next request.
    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_out_vld && i_out_stall) |=> (r_state == S_FIN))
        else $error("result overwritten while stalled");

    // Only poll ticks report reaped slots.
    a_reap_only_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_o_status != STAT_POLLED) |-> (r_o_reaped == '0))
        else $error("reaped count on a non-poll result");
`endif

endmodule
